// File: rtl/core/cdnc_pkg.sv
package cdnc_pkg;

  // Command codes carried on in_tuser
  localparam logic [1:0] CMD_YMD  = 2'd0;
  localparam logic [1:0] CMD_YDOY = 2'd1;
  localparam logic [1:0] CMD_MJD  = 2'd2;

  localparam logic [13:0] YEAR_MIN = 14'd1858;
  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [21:0] MJD_MAX  = 22'd2973483;

  // Day index counted from 0001-01-01 (zero based) is MJD plus this bias
  localparam logic [21:0] DAY_BIAS   = 22'd678575;
  // Ordinal (one based) of MJD day zero
  localparam logic [23:0] MJD_ORIGIN = 24'd678576;

  // floor(2^32 * 400 / 146097): year estimate, never above the true quotient
  localparam logic [23:0] YR_RECIP  = 24'd11759221;
  // ceil(2^20 / 100): exact divide by 100 for values below 43690
  localparam logic [13:0] C100_RECIP = 14'd10486;

  localparam logic [8:0] DAYS_COMMON = 9'd365;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        err;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  doy;
    logic [21:0] dn;
    logic [21:0] n0;
  } ctx_t;

  // Days before the first of the month
  function automatic logic [8:0] month_base(input logic [3:0] month, input logic leap);
    logic [8:0] base;
    base = 9'd0;
    case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && month > 4'd2 && month <= 4'd12) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Leap flag of year z+1, given q = floor(z / 100)
  function automatic logic leap_after(input logic [13:0] z, input logic [7:0] q);
    logic [13:0] hund;
    logic [13:0] rem;
    hund = {6'd0, q} * 14'd100;
    rem  = z - hund;
    return (z[1:0] == 2'b11) && ((rem[6:0] != 7'd99) || (q[1:0] == 2'b11));
  endfunction

endpackage

// File: rtl/core/calendar_day_number_converter.sv
// Throughput: one transaction per cycle while out_tready is high;
// the eight pipeline stages each hold one item.
// A stage takes a new item whenever it is empty or its successor advances,
// so bubbles close up while the output waits.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers keep no reset.
module calendar_day_number_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_year[13:0], in_month[17:14], in_day[22:18], in_day_of_year[31:23],
  // in_day_number[53:32], zero[55:54]
  input  logic [55:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_day_number[21:0], out_year[35:22], out_month[39:36], out_day[44:40],
  // out_day_of_year[53:45], leap_year[54], zero[55]
  output logic [55:0] out_tdata,
  // range_error[0]
  output logic        out_tuser
);

  logic [7:0] vld_r;
  logic [7:0] stage_en;

  // stage 1
  cdnc_pkg::ctx_t ctx1_r, ctx1_nxt;
  // stage 2
  cdnc_pkg::ctx_t ctx2_r;
  logic [45:0]    prod2_r, prod2_nxt;
  // stage 3
  cdnc_pkg::ctx_t ctx3_r;
  logic [13:0]    za3_r, za3_nxt, zb3_r, zb3_nxt;
  logic [27:0]    qpa3_r, qpa3_nxt, qpb3_r, qpb3_nxt;
  // stage 4
  cdnc_pkg::ctx_t ctx4_r;
  logic [13:0]    za4_r, zb4_r;
  logic [7:0]     qa4_r, qa4_nxt, qb4_r, qb4_nxt;
  logic [22:0]    z365a4_r, z365a4_nxt, z365b4_r, z365b4_nxt;
  logic           leapa4_r, leapa4_nxt, leapb4_r, leapb4_nxt;
  // stage 5
  cdnc_pkg::ctx_t ctx5_r;
  logic [13:0]    za5_r, zb5_r;
  logic [22:0]    da5_r, da5_nxt, db5_r, db5_nxt;
  logic           leapa5_r, leapb5_r;
  // stage 6
  cdnc_pkg::ctx_t ctx6_r, ctx6_nxt;
  logic [13:0]    year6_r, year6_nxt;
  logic           leap6_r, leap6_nxt;
  logic [8:0]     doy6_r, doy6_nxt;
  logic [23:0]    off6_r, off6_nxt;
  logic [23:0]    diffa6, diffb6, diffsel6;
  // stage 7
  cdnc_pkg::ctx_t ctx7_r, ctx7_nxt;
  logic [13:0]    year7_r;
  logic           leap7_r;
  logic [8:0]     doy7_r;
  logic [21:0]    mjd7_r, mjd7_nxt;
  logic [3:0]     month7_r, month7_nxt;
  logic [23:0]    sum7;
  logic [3:0]     cnt7;
  // stage 8 (output)
  logic [55:0]    odata_r, odata_nxt;
  logic           oerr_r, oerr_nxt;
  logic [4:0]     day8;

  // stage enables: a stage loads when empty or when its successor moves on
  always_comb begin
    stage_en[7] = !vld_r[7] || out_tready;
    for (int k = 6; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k + 1];
    end
  end

  assign in_tready  = stage_en[0];
  assign out_tvalid = vld_r[7];
  assign out_tdata  = odata_r;
  assign out_tuser  = oerr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 7; k >= 1; k--) begin
        if (stage_en[k]) begin
          vld_r[k] <= vld_r[k - 1];
        end
      end
      if (stage_en[0]) begin
        vld_r[0] <= in_tvalid;
      end
    end
  end

  // stage 1: unpack, range checks on the raw fields, day index for the inverse path
  always_comb begin
    ctx1_nxt.cmd   = in_tuser;
    ctx1_nxt.year  = in_tdata[13:0];
    ctx1_nxt.month = in_tdata[17:14];
    ctx1_nxt.day   = in_tdata[22:18];
    ctx1_nxt.doy   = in_tdata[31:23];
    ctx1_nxt.dn    = in_tdata[53:32];
    ctx1_nxt.n0    = in_tdata[53:32] + cdnc_pkg::DAY_BIAS;
    case (in_tuser)
      cdnc_pkg::CMD_YMD, cdnc_pkg::CMD_YDOY: begin
        ctx1_nxt.err = (in_tdata[13:0] < cdnc_pkg::YEAR_MIN) ||
                       (in_tdata[13:0] > cdnc_pkg::YEAR_MAX);
      end
      cdnc_pkg::CMD_MJD: ctx1_nxt.err = in_tdata[53:32] > cdnc_pkg::MJD_MAX;
      default:           ctx1_nxt.err = 1'b1;
    endcase
  end

  // stage 2: year estimate, day index times 400/146097
  assign prod2_nxt = {24'd0, ctx1_r.n0} * {22'd0, cdnc_pkg::YR_RECIP};

  // stage 3: pick candidate years, divide by 100
  always_comb begin
    za3_nxt  = (ctx2_r.cmd == cdnc_pkg::CMD_MJD) ? prod2_r[45:32] : ctx2_r.year - 14'd1;
    zb3_nxt  = prod2_r[45:32] + 14'd1;
    qpa3_nxt = {14'd0, za3_nxt} * {14'd0, cdnc_pkg::C100_RECIP};
    qpb3_nxt = {14'd0, zb3_nxt} * {14'd0, cdnc_pkg::C100_RECIP};
  end

  // stage 4: century counts, leap flags, 365 days per year
  always_comb begin
    qa4_nxt    = qpa3_r[27:20];
    qb4_nxt    = qpb3_r[27:20];
    z365a4_nxt = {9'd0, za3_r} * 23'd365;
    z365b4_nxt = {9'd0, zb3_r} * 23'd365;
    leapa4_nxt = cdnc_pkg::leap_after(za3_r, qa4_nxt);
    leapb4_nxt = cdnc_pkg::leap_after(zb3_r, qb4_nxt);
  end

  // stage 5: days before the first of January of each candidate year
  always_comb begin
    da5_nxt = z365a4_r + {11'd0, za4_r[13:2]} - {15'd0, qa4_r} + {17'd0, qa4_r[7:2]};
    db5_nxt = z365b4_r + {11'd0, zb4_r[13:2]} - {15'd0, qb4_r} + {17'd0, qb4_r[7:2]};
  end

  // stage 6: settle year and day of year, validate month/day or day-of-year input
  always_comb begin
    ctx6_nxt  = ctx5_r;
    diffa6    = {2'd0, ctx5_r.n0} - {1'b0, da5_r};
    diffb6    = {2'd0, ctx5_r.n0} - {1'b0, db5_r};
    diffsel6  = diffa6;
    off6_nxt  = {1'b0, da5_r} - cdnc_pkg::MJD_ORIGIN;
    year6_nxt = ctx5_r.year;
    leap6_nxt = leapa5_r;
    doy6_nxt  = ctx5_r.doy;
    case (ctx5_r.cmd)
      cdnc_pkg::CMD_MJD: begin
        if (!diffb6[23]) begin
          diffsel6  = diffb6;
          year6_nxt = zb5_r + 14'd1;
          leap6_nxt = leapb5_r;
        end else begin
          year6_nxt = za5_r + 14'd1;
        end
        doy6_nxt = diffsel6[8:0] + 9'd1;
      end
      cdnc_pkg::CMD_YMD: begin
        doy6_nxt = cdnc_pkg::month_base(ctx5_r.month, leapa5_r) + {4'd0, ctx5_r.day};
        if (ctx5_r.month == 4'd0 || ctx5_r.month > 4'd12 || ctx5_r.day == 5'd0 ||
            ctx5_r.day > cdnc_pkg::month_len(ctx5_r.month, leapa5_r)) begin
          ctx6_nxt.err = 1'b1;
        end
      end
      cdnc_pkg::CMD_YDOY: begin
        if (ctx5_r.doy == 9'd0 ||
            ctx5_r.doy > cdnc_pkg::DAYS_COMMON + {8'd0, leapa5_r}) begin
          ctx6_nxt.err = 1'b1;
        end
      end
      default: ctx6_nxt.err = 1'b1;
    endcase
  end

  // stage 7: day number of the forward path, month from day of year
  always_comb begin
    ctx7_nxt = ctx6_r;
    sum7     = off6_r + {15'd0, doy6_r};
    if (ctx6_r.cmd == cdnc_pkg::CMD_MJD) begin
      mjd7_nxt = ctx6_r.dn;
    end else begin
      mjd7_nxt = sum7[21:0];
      // drop dates before day zero
      if (sum7[23]) begin
        ctx7_nxt.err = 1'b1;
      end
    end
    cnt7 = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (doy6_r > cdnc_pkg::month_base(4'(k + 1), leap6_r)) begin
        cnt7 = cnt7 + 4'd1;
      end
    end
    month7_nxt = cnt7 + 4'd1;
  end

  // stage 8: day of month, pack, zero a rejected transaction
  always_comb begin
    day8      = 5'(doy7_r - cdnc_pkg::month_base(month7_r, leap7_r));
    oerr_nxt  = ctx7_r.err;
    odata_nxt = '0;
    if (!ctx7_r.err) begin
      odata_nxt[21:0]  = mjd7_r;
      odata_nxt[35:22] = year7_r;
      odata_nxt[39:36] = month7_r;
      odata_nxt[44:40] = day8;
      odata_nxt[53:45] = doy7_r;
      odata_nxt[54]    = leap7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      ctx1_r <= ctx1_nxt;
    end
    if (stage_en[1]) begin
      ctx2_r  <= ctx1_r;
      prod2_r <= prod2_nxt;
    end
    if (stage_en[2]) begin
      ctx3_r <= ctx2_r;
      za3_r  <= za3_nxt;
      zb3_r  <= zb3_nxt;
      qpa3_r <= qpa3_nxt;
      qpb3_r <= qpb3_nxt;
    end
    if (stage_en[3]) begin
      ctx4_r   <= ctx3_r;
      za4_r    <= za3_r;
      zb4_r    <= zb3_r;
      qa4_r    <= qa4_nxt;
      qb4_r    <= qb4_nxt;
      z365a4_r <= z365a4_nxt;
      z365b4_r <= z365b4_nxt;
      leapa4_r <= leapa4_nxt;
      leapb4_r <= leapb4_nxt;
    end
    if (stage_en[4]) begin
      ctx5_r   <= ctx4_r;
      za5_r    <= za4_r;
      zb5_r    <= zb4_r;
      da5_r    <= da5_nxt;
      db5_r    <= db5_nxt;
      leapa5_r <= leapa4_r;
      leapb5_r <= leapb4_r;
    end
    if (stage_en[5]) begin
      ctx6_r  <= ctx6_nxt;
      year6_r <= year6_nxt;
      leap6_r <= leap6_nxt;
      doy6_r  <= doy6_nxt;
      off6_r  <= off6_nxt;
    end
    if (stage_en[6]) begin
      ctx7_r   <= ctx7_nxt;
      year7_r  <= year6_r;
      leap7_r  <= leap6_r;
      doy7_r   <= doy6_r;
      mjd7_r   <= mjd7_nxt;
      month7_r <= month7_nxt;
    end
    if (stage_en[7]) begin
      odata_r <= odata_nxt;
      oerr_r  <= oerr_nxt;
    end
  end

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 56'd0)
    else $error("rejected transaction carries data");

  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[39:36] >= 4'd1 && out_tdata[39:36] <= 4'd12 &&
      out_tdata[44:40] != 5'd0 && out_tdata[53:45] != 9'd0)
    else $error("accepted date has a zero field");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> vld_r == 8'hFF)
    else $error("input stalled while a stage is empty");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  // cmd 3 has no meaning in the block and must be rejected
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  doy;
    logic [21:0] dn;
  } conv_req_t;

  typedef struct packed {
    logic        err;
    logic        leap;
    logic [8:0]  doy;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] dn;
  } date_result_t;

  typedef struct packed {
    conv_req_t    req;
    logic         typed;
    date_result_t want;
  } stim_row_t;

  localparam date_result_t REJECTED = '{err: 1'b1, default: '0};
  localparam date_result_t DAY_ZERO = '{err: 1'b0, leap: 1'b0, doy: 9'd321, day: 5'd17,
                                        month: 4'd11, year: 14'd1858, dn: 22'd0};
  localparam date_result_t LAST_DAY = '{err: 1'b0, leap: 1'b0, doy: 9'd365, day: 5'd31,
                                        month: 4'd12, year: 14'd9999, dn: 22'd2973483};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;

  date_result_t expected_dates[$];
  stim_row_t    directed_rows[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           long_hold_req = 1'b0;

  calendar_day_number_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_days(input int y, input int m);
    case (m)
      2:           return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int ordinal_day(input int y, input int m, input int d);
    int sum;
    sum = d;
    for (int k = 1; k < m; k++) begin
      sum += month_days(y, k);
    end
    return sum;
  endfunction

  // Integer Julian day formula, shifted to the modified day count
  function automatic int ymd_to_mjd(input int y, input int m, input int d);
    int a;
    a = (m <= 2) ? -1 : 0;
    return d - 32075 + 1461 * (y + 4800 + a) / 4 + 367 * (m - 2 - 12 * a) / 12
           - 3 * ((y + 4900 + a) / 100) / 4 - 2400001;
  endfunction

  function automatic date_result_t convert_calendar(input conv_req_t req);
    date_result_t res;
    bit ok;
    int y, m, d, doy, dn, mjd, rem;
    int z, alpha, a, b, c, dd, e;
    y   = int'(req.year);
    m   = int'(req.month);
    d   = int'(req.day);
    doy = int'(req.doy);
    dn  = int'(req.dn);
    mjd = 0;
    ok  = 1'b1;
    if (req.cmd == cdnc_pkg::CMD_YMD || req.cmd == cdnc_pkg::CMD_YDOY) begin
      if (y < int'(cdnc_pkg::YEAR_MIN) || y > int'(cdnc_pkg::YEAR_MAX)) begin
        ok = 1'b0;
      end else if (req.cmd == cdnc_pkg::CMD_YMD) begin
        if (m < 1 || m > 12 || d < 1 || d > month_days(y, m)) ok = 1'b0;
      end else if (doy < 1 || doy > (is_leap_year(y) ? 366 : 365)) begin
        ok = 1'b0;
      end else begin
        // walk the months down to the day of month
        m = 1;
        rem = doy;
        while (m < 12 && rem > month_days(y, m)) begin
          rem -= month_days(y, m);
          m++;
        end
        d = rem;
      end
      if (ok) begin
        mjd = ymd_to_mjd(y, m, d);
        if (mjd < 0 || mjd > int'(cdnc_pkg::MJD_MAX)) ok = 1'b0;
      end
    end else if (req.cmd == cdnc_pkg::CMD_MJD) begin
      if (dn > int'(cdnc_pkg::MJD_MAX)) begin
        ok = 1'b0;
      end else begin
        mjd   = dn;
        z     = dn + 2400001;
        alpha = (4 * z - 7468865) / 146097;
        a     = z + 1 + alpha - alpha / 4;
        b     = a + 1524;
        c     = (20 * b - 2442) / 7305;
        dd    = (1461 * c) / 4;
        e     = (10000 * (b - dd)) / 306001;
        d     = b - dd - (306001 * e) / 10000;
        m     = (e <= 13) ? e - 1 : e - 13;
        y     = (m >= 3) ? c - 4716 : c - 4715;
        if (m < 1 || m > 12) ok = 1'b0;
      end
    end else begin
      ok = 1'b0;
    end
    if (!ok) return REJECTED;
    res.err   = 1'b0;
    res.leap  = is_leap_year(y);
    res.doy   = 9'(ordinal_day(y, m, d));
    res.day   = 5'(d);
    res.month = 4'(m);
    res.year  = 14'(y);
    res.dn    = 22'(mjd);
    return res;
  endfunction

  // Mostly well-formed requests with random content, the rest raw noise
  function automatic conv_req_t random_request();
    conv_req_t req;
    int pick, y;
    req.cmd   = 2'($urandom);
    req.year  = 14'($urandom);
    req.month = 4'($urandom);
    req.day   = 5'($urandom);
    req.doy   = 9'($urandom);
    req.dn    = 22'($urandom);
    pick = int'($urandom_range(99));
    // lean on the first year so dates before day zero show up
    y = ($urandom_range(9) == 0) ? int'(cdnc_pkg::YEAR_MIN) :
                                   int'($urandom_range(9999, 1858));
    if (pick < 35) begin
      req.cmd   = cdnc_pkg::CMD_YMD;
      req.year  = 14'(y);
      req.month = 4'($urandom_range(12, 1));
      req.day   = 5'($urandom_range(month_days(y, int'(req.month)), 1));
    end else if (pick < 60) begin
      req.cmd  = cdnc_pkg::CMD_YDOY;
      req.year = 14'(y);
      req.doy  = 9'($urandom_range(is_leap_year(y) ? 366 : 365, 1));
    end else if (pick < 88) begin
      req.cmd = cdnc_pkg::CMD_MJD;
      req.dn  = 22'($urandom_range(int'(cdnc_pkg::MJD_MAX), 0));
    end
    return req;
  endfunction

  task automatic add_row(input logic [1:0] c, input int y, input int m, input int d,
                         input int doy, input int dn, input logic typed,
                         input date_result_t want);
    stim_row_t row;
    row.req.cmd   = c;
    row.req.year  = 14'(y);
    row.req.month = 4'(m);
    row.req.day   = 5'(d);
    row.req.doy   = 9'(doy);
    row.req.dn    = 22'(dn);
    row.typed     = typed;
    row.want      = want;
    directed_rows.push_back(row);
  endtask

  // Offer one request and hold it until the block takes the transaction
  task automatic send_request(input conv_req_t req, input logic typed,
                              input date_result_t want);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, req.dn, req.doy, req.day, req.month, req.year};
    in_tuser  <= req.cmd;
    do @(posedge clk); while (in_tready !== 1'b1);
    expected_dates.push_back(typed ? want : convert_calendar(req));
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_request(random_request(), 1'b0, REJECTED);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    date_result_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (expected_dates.size() == 0) begin
        $error("result transaction with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("out_day_number", want.dn, out_tdata[21:0]);
        check_field("out_year", want.year, out_tdata[35:22]);
        check_field("out_month", want.month, out_tdata[39:36]);
        check_field("out_day", want.day, out_tdata[44:40]);
        check_field("out_day_of_year", want.doy, out_tdata[53:45]);
        check_field("leap_year", want.leap, out_tdata[54]);
        check_field("range_error", want.err, out_tuser);
      end
    end
  end

  // Receiver: random back-pressure, or one long hold when asked
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= cdnc_pkg::CMD_YMD;

    add_row(cdnc_pkg::CMD_YMD, 1858, 11, 17, 511, 4194303, 1'b1, DAY_ZERO);
    add_row(cdnc_pkg::CMD_YMD, 1858, 11, 16, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 9999, 12, 31, 0, 0, 1'b1, LAST_DAY);
    add_row(cdnc_pkg::CMD_YMD, 10000, 1, 1, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 16383, 15, 31, 511, 4194303, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 1857, 12, 31, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 2000, 0, 1, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 2000, 13, 1, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 2000, 1, 0, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 2021, 4, 31, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 2000, 2, 29, 0, 0, 1'b0, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 1900, 2, 29, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YMD, 2024, 12, 31, 0, 0, 1'b0, REJECTED);
    add_row(cdnc_pkg::CMD_YDOY, 1858, 15, 31, 321, 4194303, 1'b1, DAY_ZERO);
    add_row(cdnc_pkg::CMD_YDOY, 1858, 1, 1, 1, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YDOY, 2000, 0, 0, 366, 0, 1'b0, REJECTED);
    add_row(cdnc_pkg::CMD_YDOY, 2001, 0, 0, 366, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YDOY, 2001, 0, 0, 0, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_YDOY, 9999, 0, 0, 511, 0, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_MJD, 16383, 15, 31, 511, 0, 1'b1, DAY_ZERO);
    add_row(cdnc_pkg::CMD_MJD, 0, 0, 0, 0, 2973483, 1'b1, LAST_DAY);
    add_row(cdnc_pkg::CMD_MJD, 0, 0, 0, 0, 2973484, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_MJD, 0, 0, 0, 0, 4194303, 1'b1, REJECTED);
    add_row(cdnc_pkg::CMD_MJD, 0, 0, 0, 0, 51544, 1'b0, REJECTED);
    add_row(CMD_UNUSED, 16383, 15, 31, 511, 4194303, 1'b1, REJECTED);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_for_drain();

    run_random(PHASE_ITEMS, 0, 0);
    wait_for_drain();
    run_random(PHASE_ITEMS, 48, 0);
    wait_for_drain();
    run_random(PHASE_ITEMS, 0, 48);
    wait_for_drain();
    run_random(PHASE_ITEMS, 10, 10);

    // hold the output off long enough for the pipeline to fill and stall the input
    long_hold_req = 1'b1;
    run_random(60, 0, 0);
    wait_for_drain();
    run_random(40, 10, 10);
    wait_for_drain();

    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
